// File: src/ostf_pkg.sv
// ostf_pkg: shared widths, command and status codes, and control types
// for the owner tagged shared fifo. No dependencies.
package ostf_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OWNER_W  = 16;
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ENTRY_W  = DATA_W + OWNER_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LENGTH = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // tag value that matches every entry on read and length
  localparam logic [OWNER_W-1:0] ANY_OWNER = '0;

  // sequencer to match unit control
  typedef struct packed {
    logic clr;
    logic step;
  } match_ctrl_t;

endpackage

// File: src/ostf_ram.sv
// ostf_ram: generic single write port, single read port ram with
// registered read data. No dependencies.
module ostf_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ostf_match.sv
// ostf_match: shared tag compare unit with the match counter and the
// limit cap used by length queries. Depends on ostf_pkg.
module ostf_match #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ostf_pkg::match_ctrl_t             ctrl_i,
  input  logic [ostf_pkg::OWNER_W-1:0]      entry_owner_i,
  input  logic [ostf_pkg::OWNER_W-1:0]      query_owner_i,
  input  logic [ostf_pkg::LIMIT_W-1:0]      limit_i,
  output logic                              hit_o,
  output logic [ostf_pkg::LIMIT_W-1:0]      count_o
);
  import ostf_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] lim_ext;
  logic [CMP_W-1:0] capped;

  // tag compare, zero query matches anything
  assign hit_o = (query_owner_i == ANY_OWNER) || (entry_owner_i == query_owner_i);

  // match counter
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clr) begin
      cnt_d = '0;
    end else if (ctrl_i.step && hit_o) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // nonzero limit caps the count, result keeps the low bits
  assign cnt_ext = CMP_W'(cnt_q);
  assign lim_ext = CMP_W'(limit_i);
  assign capped  = ((limit_i != '0) && (cnt_ext > lim_ext)) ? lim_ext : cnt_ext;
  assign count_o = capped[LIMIT_W-1:0];

endmodule

// File: src/owner_tagged_shared_fifo.sv
// owner_tagged_shared_fifo: top level with the sequencer, entry ram and
// shared tag compare unit. Depends on ostf_pkg, ostf_ram and ostf_match.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  command  | start / busy       | cmd_i, write_data_i, owner_i, limit_i
//  result   | done_o (strobe)    | status_o, read_data_o, count_o
//
// Write, unused command: result strobe one cycle after the transaction.
// Read: each entry up to the oldest match is scanned in S_SCAN_RD and S_SCAN_CHK,
//   then each younger entry is moved down one place in S_SH_RD and S_SH_WR, and a
//   last S_SH_RD ends it; the single ram port pair carries one entry read or move at a time.
// Length, read with no match: every stored entry is scanned in S_SCAN_RD and S_SCAN_CHK, then a last S_SCAN_RD ends it.
// Reset clears the fill count and the sequencer; ram contents stay undefined.
// The result is held one cycle only; the receiver cannot stall it.
module owner_tagged_shared_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [ostf_pkg::CMD_W-1:0]      cmd_i,
  input  logic [ostf_pkg::DATA_W-1:0]     write_data_i,
  input  logic [ostf_pkg::OWNER_W-1:0]    owner_i,
  input  logic [ostf_pkg::LIMIT_W-1:0]    limit_i,
  output logic                            done_o,
  output logic [ostf_pkg::STATUS_W-1:0]   status_o,
  output logic [ostf_pkg::DATA_W-1:0]     read_data_o,
  output logic [ostf_pkg::LIMIT_W-1:0]    count_o
);
  import ostf_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // sequencer states
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] S_SCAN_RD  = 3'd1;
  localparam logic [ST_W-1:0] S_SCAN_CHK = 3'd2;
  localparam logic [ST_W-1:0] S_SH_RD    = 3'd3;
  localparam logic [ST_W-1:0] S_SH_WR    = 3'd4;

  logic [ST_W-1:0]     state_q, state_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]    idx_plus;
  logic [CMD_W-1:0]    cmd_q;
  logic [OWNER_W-1:0]  owner_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0]   rdata_q, rdata_d;
  logic [LIMIT_W-1:0]  cnt_out_q, cnt_out_d;
  logic                accept;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  match_ctrl_t         mctl;
  logic                hit;
  logic [LIMIT_W-1:0]  match_count;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign idx_plus = idx_q + 1'b1;

  // entry store, owner tag in the upper bits
  ostf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared tag compare and match counter
  ostf_match #(
    .DEPTH (DEPTH)
  ) u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (mctl),
    .entry_owner_i (ram_rdata[ENTRY_W-1:DATA_W]),
    .query_owner_i (owner_q),
    .limit_i       (limit_q),
    .hit_o         (hit),
    .count_o       (match_count)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    fill_d    = fill_q;
    done_d    = 1'b0;
    status_d  = status_q;
    rdata_d   = rdata_q;
    cnt_out_d = cnt_out_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[IDX_W-1:0];
    mctl      = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d     = '0;
          mctl.clr  = 1'b1;
          status_d  = ST_OK;
          rdata_d   = '0;
          cnt_out_d = '0;
          case (cmd_i)
            CMD_WRITE: begin
              if (fill_q == FULL_CNT) begin
                status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = fill_q[IDX_W-1:0];
                ram_wdata = {owner_i, write_data_i};
                fill_d    = fill_q + 1'b1;
              end
              done_d = 1'b1;
            end
            CMD_READ, CMD_LENGTH: begin
              state_d = S_SCAN_RD;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx_q == fill_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == CMD_READ) begin
            status_d = ST_EMPTY;
          end else begin
            cnt_out_d = match_count;
          end
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if ((cmd_q == CMD_READ) && hit) begin
          rdata_d = ram_rdata[DATA_W-1:0];
          state_d = S_SH_RD;
        end else begin
          mctl.step = (cmd_q == CMD_LENGTH);
          idx_d     = idx_plus;
          state_d   = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        // close the gap left by the removed entry, one entry per pass
        if (idx_plus == fill_q) begin
          fill_d  = fill_q - 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_raddr = idx_plus[IDX_W-1:0];
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_plus;
        state_d = S_SH_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      owner_q <= owner_i;
      limit_q <= limit_i;
    end
    status_q  <= status_d;
    rdata_q   <= rdata_d;
    cnt_out_q <= cnt_out_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;
  assign count_o     = cnt_out_q;

  // fill count never passes the buffer depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count above depth");

  // a result always comes with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while sequencer busy");

  // a successful write adds exactly one entry
  a_write_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (cmd_q == CMD_WRITE) && (status_q == ST_OK))
      |-> (fill_q == CNT_W'($past(fill_q) + 1'b1)))
    else $error("write did not add one entry");

  // a successful read removes exactly one entry
  a_read_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (cmd_q == CMD_READ) && (status_q == ST_OK))
      |-> (fill_q == CNT_W'($past(fill_q) - 1'b1)))
    else $error("read did not remove one entry");

endmodule
